// ===== design/assert_macros.svh =====
// assertion helpers for the predictor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BFP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define BFP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/bfp_pkg.sv =====
// ----------------------------------------------------------------------------
// bfp_pkg
// types, widths and constants of the ball friction position predictor
// ----------------------------------------------------------------------------
`default_nettype none

package bfp_pkg;

  localparam int DATA_W      = 16;
  localparam int STEPS_W     = 10;
  localparam int MAX_STEPS_DEF = 512;
  localparam int STILL_Q12   = 41;

  // operand widths of the shared units
  localparam int MUL_W       = 32;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int TOT_W       = 45;   // sum of step distances, up to 8192 steps
  localparam int TOT_LO_W    = 23;
  localparam int ENERGY_W    = 53;
  localparam int DVD_W       = 61;
  localparam int DVS_W       = 32;
  localparam int SQ_W        = 32;
  localparam int ROOT_W      = SQ_W / 2;

  typedef enum logic [1:0] {
    CFG_MASS     = 2'd0,
    CFG_FRICTION = 2'd1,
    CFG_TSTEP    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  pos_x;
    logic signed [DATA_W-1:0]  pos_y;
    logic signed [DATA_W-1:0]  vel_x;
    logic signed [DATA_W-1:0]  vel_y;
    logic        [STEPS_W-1:0] steps;
  } bfp_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pred_x;
    logic signed [DATA_W-1:0] pred_y;
    logic                     moved;
  } bfp_out_t;

  typedef enum logic [17:0] {
    S_IDLE = 18'b000000000000000001,
    S_SQX  = 18'b000000000000000010,
    S_SQY  = 18'b000000000000000100,
    S_SPD  = 18'b000000000000001000,
    S_SPW  = 18'b000000000000010000,
    S_CHK  = 18'b000000000000100000,
    S_DS   = 18'b000000000001000000,
    S_WK   = 18'b000000000010000000,
    S_VV   = 18'b000000000100000000,
    S_EN   = 18'b000000001000000000,
    S_CMP  = 18'b000000010000000000,
    S_DVW  = 18'b000000100000000000,
    S_SQW  = 18'b000001000000000000,
    S_OLO  = 18'b000010000000000000,
    S_OHI  = 18'b000100000000000000,
    S_ODV  = 18'b001000000000000000,
    S_ODW  = 18'b010000000000000000,
    S_OUT  = 18'b100000000000000000
  } bfp_state_t;

endpackage

`default_nettype wire

// ===== design/bfp_div.sv =====
// ----------------------------------------------------------------------------
// bfp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bfp_div import bfp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic      [DVD_W-1:0] quot
);

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem[DVS_W-1:0], quot[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= divisor;
      quot <= dividend;
    end else if (busy) begin
      rem  <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quot <= {quot[DVD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== design/bfp_sqrt.sv =====
// ----------------------------------------------------------------------------
// bfp_sqrt
// floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bfp_sqrt import bfp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SQ_W-1:0]   radicand,
  output logic                   done,
  output logic      [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 2;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SQ_W-1:0]  rad;
  logic [REM_W-1:0] rem;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             fits;

  assign rem_sh = {rem, rad[SQ_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[SQ_W-3:0], 2'b00};
      rem  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== design/ball_friction_position_predictor.sv =====
// a ball below the stillness speed goes straight to the result; otherwise the steps
//   run in turn up to the clamped limit or until the ball stops, then the two axis offsets
// throughput: one word at a time, the next word is taken once the result has left
// the per-step cost is set by the shared divider and square root
// reset: synchronous, restores mass, friction and time step and empties the block
`default_nettype none

`include "assert_macros.svh"

module ball_friction_position_predictor import bfp_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // input words
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bfp_in_t           in_data,
  // result words
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bfp_out_t               out_data,
  // register writes
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data
);

  // step counter wide enough for both the field and the clamp limit
  localparam int LIM_W = $clog2(MAX_STEPS + 1);
  localparam int CW    = (LIM_W > STEPS_W) ? LIM_W : STEPS_W;
  localparam logic [CW-1:0] STEP_LIM = CW'(MAX_STEPS);

  // configuration registers
  logic [DATA_W-1:0] mass;
  logic [DATA_W-1:0] friction;
  logic [DATA_W-1:0] tstep;

  // sequencer and working registers
  bfp_state_t          state;
  bfp_in_t             item;
  logic [DATA_W-1:0]   m_eff;
  logic [CW-1:0]       n_lim;
  logic [CW-1:0]       cnt;
  logic [ROOT_W-1:0]   speed;
  logic [ROOT_W-1:0]   vel;
  logic [TOT_W-1:0]    total;
  logic [ENERGY_W-1:0] work2;
  logic [SQ_W-1:0]     sumsq;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   lo;
  logic                ax;

  // shared multiplier operands
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;

  logic [DATA_W-1:0] mag_x;
  logic [DATA_W-1:0] mag_y;
  logic [DATA_W-1:0] mag;
  logic              neg;
  logic [ENERGY_W-1:0] energy2;
  logic [CW-1:0]     steps_ext;

  // divider and square root
  logic              dv_start;
  logic [DVD_W-1:0]  dv_dividend;
  logic [DVS_W-1:0]  dv_divisor;
  logic              dv_busy;
  logic              dv_done;
  logic [DVD_W-1:0]  dv_quot;
  logic              sq_start;
  logic [SQ_W-1:0]   sq_rad;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;

  // axis offset and saturation
  logic [DVS_W-1:0]        q;
  logic signed [DVS_W+1:0] sum;
  logic signed [DATA_W-1:0] sat;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cfg_ready = 1'b1;

  assign mag_x     = item.vel_x[DATA_W-1] ? DATA_W'(-item.vel_x) : item.vel_x;
  assign mag_y     = item.vel_y[DATA_W-1] ? DATA_W'(-item.vel_y) : item.vel_y;
  assign mag       = ax ? mag_y : mag_x;
  assign neg       = ax ? item.vel_y[DATA_W-1] : item.vel_x[DATA_W-1];
  assign energy2   = {prod[ENERGY_W-5:0], 4'b0000};
  assign steps_ext = CW'(in_data.steps);

  // register writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      mass     <= DATA_W'(1884);
      friction <= DATA_W'(287);
      tstep    <= DATA_W'(1092);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MASS:     mass     <= cfg_data;
        CFG_FRICTION: friction <= cfg_data;
        CFG_TSTEP:    tstep    <= cfg_data;
        default:      ;
      endcase
    end
  end

  // multiplier operand selection by state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQX: begin mul_a = MUL_W'(mag_x);  mul_b = MUL_W'(mag_x); end
      S_SQY: begin mul_a = MUL_W'(mag_y);  mul_b = MUL_W'(mag_y); end
      S_DS:  begin mul_a = MUL_W'(vel);    mul_b = MUL_W'(tstep); end
      S_WK:  begin mul_a = MUL_W'(friction); mul_b = prod[MUL_W-1:0]; end
      S_VV:  begin mul_a = MUL_W'(vel);    mul_b = MUL_W'(vel); end
      S_EN:  begin mul_a = MUL_W'(m_eff);  mul_b = prod[MUL_W-1:0]; end
      S_OLO: begin mul_a = MUL_W'(mag);    mul_b = MUL_W'(total[TOT_LO_W-1:0]); end
      S_OHI: begin mul_a = MUL_W'(mag);    mul_b = MUL_W'(total[TOT_W-1:TOT_LO_W]); end
      default: ;
    endcase
  end

  // unit starts and operands
  always_comb begin
    dv_start    = 1'b0;
    dv_dividend = DVD_W'(energy2 - work2);
    dv_divisor  = DVS_W'(m_eff);
    sq_start    = 1'b0;
    sq_rad      = SQ_W'(sumsq + prod[SQ_W-1:0]);
    if (state == S_CMP && energy2 > work2) begin
      dv_start = 1'b1;
    end
    if (state == S_ODV) begin
      dv_start    = 1'b1;
      // rounding half away from zero: add half the divisor
      dv_dividend = DVD_W'(lo) + DVD_W'({prod, TOT_LO_W'(0)})
                  + DVD_W'({speed, 15'd0});
      dv_divisor  = {speed, 16'd0};
    end
    if (state == S_SPD) begin
      sq_start = 1'b1;
    end
    if (state == S_DVW && dv_done) begin
      sq_start = 1'b1;
      sq_rad   = dv_quot[SQ_W+3:4];
    end
  end

  // signed offset applied to the position, then saturated
  always_comb begin
    q   = dv_quot[DVS_W-1:0];
    sum = (DVS_W+2)'(ax ? item.pos_y : item.pos_x)
        + (neg ? -$signed({2'b00, q}) : $signed({2'b00, q}));
    if (sum > (DVS_W+2)'(32767)) begin
      sat = 16'sh7fff;
    end else if (sum < -(DVS_W+2)'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item  <= in_data;
            m_eff <= (mass == '0) ? DATA_W'(1) : mass;
            n_lim <= (steps_ext > STEP_LIM) ? STEP_LIM : steps_ext;
            state <= S_SQX;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          sumsq <= prod[SQ_W-1:0];
          state <= S_SPD;
        end
        S_SPD: state <= S_SPW;
        S_SPW: begin
          if (sq_done) begin
            speed <= sq_root;
            vel   <= sq_root;
            total <= '0;
            cnt   <= '0;
            ax    <= 1'b0;
            if (sq_root < ROOT_W'(STILL_Q12)) begin
              // still ball: position goes back unchanged
              out_data <= '{pred_x: item.pos_x, pred_y: item.pos_y, moved: 1'b0};
              state    <= S_OUT;
            end else begin
              out_data.moved <= 1'b1;
              state          <= S_CHK;
            end
          end
        end
        S_CHK: state <= (cnt == n_lim) ? S_OLO : S_DS;
        S_DS:  state <= S_WK;
        S_WK: begin
          total <= total + TOT_W'(prod[MUL_W-1:0]);
          cnt   <= cnt + 1'b1;
          state <= S_VV;
        end
        S_VV: begin
          work2 <= ENERGY_W'({prod[ENERGY_W-3:0], 1'b0});
          state <= S_EN;
        end
        S_EN:  state <= S_CMP;
        S_CMP: state <= (energy2 > work2) ? S_DVW : S_OLO;
        S_DVW: if (dv_done) state <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            if (sq_root == '0) begin
              state <= S_OLO;
            end else begin
              vel   <= sq_root;
              state <= S_CHK;
            end
          end
        end
        S_OLO: state <= S_OHI;
        S_OHI: begin
          lo    <= prod;
          state <= S_ODV;
        end
        S_ODV: state <= S_ODW;
        S_ODW: begin
          if (dv_done) begin
            if (ax) begin
              out_data.pred_y <= sat;
              state           <= S_OUT;
            end else begin
              out_data.pred_x <= sat;
              ax              <= 1'b1;
              state           <= S_OLO;
            end
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  bfp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .busy     (dv_busy),
    .done     (dv_done),
    .quot     (dv_quot)
  );

  bfp_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  // speed never rises from one step to the next
  `BFP_ASSERT_NXT(a_vel_falls, clk, rst, (state == S_SQW && sq_done), (vel <= $past(vel)))
  // divider only started when idle and with a nonzero divisor
  `BFP_ASSERT_IMP(a_div_start, clk, rst, dv_start, (!dv_busy && dv_divisor != '0))
  // step count never passes the clamped limit
  `BFP_ASSERT_IMP(a_cnt_lim, clk, rst, (state == S_CHK), (cnt <= n_lim))
  // a still ball leaves with its own position
  `BFP_ASSERT_IMP(a_still_pos, clk, rst, (out_valid && !out_data.moved),
                  (out_data.pred_x == item.pos_x && out_data.pred_y == item.pos_y))

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ball friction position predictor: a local
// fixed-point model predicts each result word, a monitor compares them in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import bfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 150000;  // above the run time of one 512-step word
  localparam int TAIL_CYCLES    = 200;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  bfp_in_t           in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  bfp_out_t          out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  // local copy of the registers
  logic [15:0] mass_reg, friction_reg, tstep_reg;

  bfp_out_t pred_q[$];
  int       err_cnt = 0;
  int       idle_cnt = 0;
  int       hold_req = 0;   // long receiver hold-off requested by a test
  int       hold_cnt = 0;
  bit       quiet = 1'b0;   // no idling on either side

  always #4 clk = ~clk;

  ball_friction_position_predictor i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // floor square root, bit by bit
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r, t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Q.28 distance along one axis back to Q.12, rounded half away from zero
  function automatic longint axis_shift(longint comp, logic [63:0] total,
                                        logic [63:0] speed);
    logic [63:0] mag, den, q;
    mag = (comp < 0) ? -comp : comp;
    den = speed << 16;
    q   = (mag * total + (den >> 1)) / den;
    return (comp < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic bfp_out_t predict_position(bfp_in_t d);
    bfp_out_t    r;
    longint      px, py, vx, vy;
    logic [63:0] m, n, speed, vel, total, ds, work2, energy2, v2, nv;
    px = longint'(d.pos_x); py = longint'(d.pos_y);
    vx = longint'(d.vel_x); vy = longint'(d.vel_y);
    n  = 64'(d.steps);
    m  = (mass_reg == 0) ? 64'd1 : 64'(mass_reg);
    speed = floor_sqrt(64'(vx * vx) + 64'(vy * vy));
    if (speed < STILL_Q12) begin
      // ball at rest: position passes straight through
      r.pred_x = d.pos_x;
      r.pred_y = d.pos_y;
      r.moved  = 1'b0;
      return r;
    end
    if (n > MAX_STEPS_DEF) n = 64'(MAX_STEPS_DEF);
    vel = speed;
    total = '0;
    for (int c = 0; c < n; c++) begin
      ds      = vel * tstep_reg;
      work2   = 2 * 64'(friction_reg) * ds;
      energy2 = (m * vel * vel) << 4;
      total  += ds;
      if (energy2 <= work2) break;
      v2 = ((energy2 - work2) / m) >> 4;
      nv = floor_sqrt(v2);
      if (nv == 0) break;
      vel = nv;
    end
    r.pred_x = clip16(px + axis_shift(vx, total, speed));
    r.pred_y = clip16(py + axis_shift(vy, total, speed));
    r.moved  = 1'b1;
    return r;
  endfunction

  // receiver idling and hold-off
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) == 0) begin
      hold_cnt = $urandom_range(20, 150);
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    bfp_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pred_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_data);
        err_cnt++;
      end else begin
        want = pred_q.pop_front();
        if (out_data.pred_x !== want.pred_x) begin
          $display("%0t: pred_x expected %h actual %h", $time, want.pred_x, out_data.pred_x);
          err_cnt++;
        end
        if (out_data.pred_y !== want.pred_y) begin
          $display("%0t: pred_y expected %h actual %h", $time, want.pred_y, out_data.pred_y);
          err_cnt++;
        end
        if (out_data.moved !== want.moved) begin
          $display("%0t: moved expected %b actual %b", $time, want.moved, out_data.moved);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) || rst)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // sender gap: mostly short, sometimes long
  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_word(bfp_in_t d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    pred_q.push_back(predict_position(d));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pred_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MASS:     mass_reg     = val;
      CFG_FRICTION: friction_reg = val;
      CFG_TSTEP:    tstep_reg    = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_unknown(logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= 2'd3;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bfp_in_t mk(int px, int py, int vx, int vy, int n);
    bfp_in_t d;
    d.pos_x = 16'(px); d.pos_y = 16'(py); d.vel_x = 16'(vx); d.vel_y = 16'(vy);
    d.steps = 10'(n);
    return d;
  endfunction

  // random word: mostly few steps, a few long look-aheads
  function automatic bfp_in_t rand_word();
    bfp_in_t d;
    d.pos_x = 16'($urandom); d.pos_y = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       begin d.vel_x = 16'($urandom_range(0, 60) - 30);
                     d.vel_y = 16'($urandom_range(0, 60) - 30); end
      1, 2:    begin d.vel_x = 16'($urandom); d.vel_y = 16'($urandom); end
      default: begin d.vel_x = 16'($urandom_range(0, 16000) - 8000);
                     d.vel_y = 16'($urandom_range(0, 16000) - 8000); end
    endcase
    d.steps = ($urandom_range(0, 24) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
    return d;
  endfunction

  task automatic test_directed();
    send_word(mk(0, 0, 0, 0, 5));                       // at rest
    send_word(mk(1000, -1000, 28, 28, 100));            // just under stillness
    send_word(mk(1000, -1000, 41, 0, 3));               // exactly at stillness
    send_word(mk(-5, 7, 4096, 0, 0));                   // moving, zero steps
    send_word(mk(0, 0, 4096, 4096, 1));
    send_word(mk(32767, 32767, 32767, 32767, 20));      // saturate high
    send_word(mk(-32768, -32768, -32768, -32768, 20));  // saturate low
    send_word(mk(0, 0, -32768, 32767, 8));
    send_word(mk(100, 200, 8192, -4096, 512));          // maximum steps
    send_word(mk(100, 200, -300, 9000, 1023));          // clamped above maximum
    send_word(mk(-32768, 32767, 1, -1, 1023));
    send_word(mk(0, 0, 16'h5555, 16'haaaa, 10'h2aa));
    send_word(mk(-1, -1, 16'haaaa, 16'h5555, 10'h155));
    drain();
  endtask

  task automatic test_config_sweep();
    write_unknown(16'hffff);                            // ignored
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: begin write_reg(CFG_MASS, 16'd0); write_reg(CFG_FRICTION, 16'd0);
                 write_reg(CFG_TSTEP, 16'd0); end          // zero mass and time step
        1: begin write_reg(CFG_MASS, 16'hffff); write_reg(CFG_FRICTION, 16'hffff);
                 write_reg(CFG_TSTEP, 16'hffff); end
        2: begin write_reg(CFG_MASS, 16'd1); write_reg(CFG_FRICTION, 16'hffff);
                 write_reg(CFG_TSTEP, 16'd1); end
        3: begin write_reg(CFG_MASS, 16'd1); write_reg(CFG_FRICTION, 16'd0);
                 write_reg(CFG_TSTEP, 16'hffff); end
        4: begin write_reg(CFG_MASS, 16'($urandom)); write_reg(CFG_FRICTION, 16'($urandom));
                 write_reg(CFG_TSTEP, 16'($urandom)); end
        default: begin write_reg(CFG_MASS, 16'd1884); write_reg(CFG_FRICTION, 16'd287);
                 write_reg(CFG_TSTEP, 16'd1092); end
      endcase
      for (int i = 0; i < 6; i++) send_word(rand_word());
      send_word(mk(0, 0, 4096, -4096, 40));
      drain();
    end
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering short words
    hold_req = 400;
    for (int i = 0; i < 6; i++) begin
      if (i % 2 == 1) send_word(mk(i, -i, 10, 5, 3));
      else            send_word(mk(i * 300, -i * 300, 4096, 2000, 0));
    end
    drain();
    // neither side idles; each word is still taken only after the last result has left
    quiet = 1'b1;
    for (int i = 0; i < 4; i++) send_word(rand_word());
    drain();
    quiet = 1'b0;
  endtask

  task automatic test_random();
    for (int i = 0; i < 35; i++) begin
      if (i == 10) quiet = 1'b1;
      if (i == 20) quiet = 1'b0;
      send_word(rand_word());
    end
    drain();
  endtask

  initial begin
    mass_reg = 16'd1884; friction_reg = 16'd287; tstep_reg = 16'd1092;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pred_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/bfp_pkg.sv
design/bfp_div.sv
design/bfp_sqrt.sv
design/ball_friction_position_predictor.sv
tb/tb_top.sv
